/* rtl/ssd_pkg.sv */
`timescale 1ns / 1ps

package ssd_pkg;

   localparam int SOURCE_ENTRIES_DEF = 16;
   localparam int SET_DEPTH_DEF      = 16;

   localparam logic [15:0] KIND_ARP  = 16'h0806;
   localparam logic [15:0] KIND_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP = 8'd6;

   localparam logic [1:0] CLASS_OTHER = 2'd0;
   localparam logic [1:0] CLASS_ARP   = 2'd1;
   localparam logic [1:0] CLASS_SYN   = 2'd2;

   localparam logic [1:0] REG_ARP_LIMIT  = 2'd0;
   localparam logic [1:0] REG_PORT_LIMIT = 2'd1;
   localparam logic [1:0] REG_HOST_LIMIT = 2'd2;

   localparam logic [7:0] ARP_LIMIT_RST  = 8'd20;
   localparam logic [3:0] PORT_LIMIT_RST = 4'd10;
   localparam logic [3:0] HOST_LIMIT_RST = 4'd10;

   typedef struct packed {
      logic load_req;
      logic idx_clr;
      logic idx_inc;
      logic rd_src;
      logic alloc;
      logic set_slot;
      logic set_full;
      logic rd_fill;
      logic cap_fill;
      logic rd_host;
      logic add_host;
      logic rd_port;
      logic add_port;
      logic wb_fill;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_class;
      logic       src_end;
      logic       tbl_full;
      logic       src_hit;
      logic       host_end;
      logic       host_hit;
      logic       port_end;
      logic       port_hit;
   } status_type;

endpackage

/* rtl/syn_scan_detector_core.sv */
`timescale 1ns / 1ps

// channel  | handshake            | payload
// req      | req_valid/req_stall  | ether_kind ip_proto syn_bit ack_bit src/dst_addr target_port
// rsp      | rsp_valid/rsp_stall  | frame_class arp/port/host_alert table_full alert_addr
// csr      | csr_we               | csr_index csr_wdata
//
// ARP and other frames go straight to the final step. A SYN first searches the
// source entries; an unknown source with a full table ends there. Otherwise it
// searches the stored addresses and then the stored ports of that source: the
// single-port source, address and port memories are walked one entry at a time.
// Reset clears only the ARP tally, source count, state and output valid, and loads default limits.
// A pending result stalls only the final step; the next transaction is
// accepted as soon as the current one has been moved to the output register.

module syn_scan_detector_core #(
   parameter int SOURCE_ENTRIES = ssd_pkg::SOURCE_ENTRIES_DEF,
   parameter int SET_DEPTH      = ssd_pkg::SET_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_ether_kind,
   input  logic [7:0]  req_ip_proto,
   input  logic        req_syn_bit,
   input  logic        req_ack_bit,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_target_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_frame_class,
   output logic        rsp_arp_alert,
   output logic        rsp_port_alert,
   output logic        rsp_host_alert,
   output logic        rsp_table_full,
   output logic [31:0] rsp_alert_addr
);

   ssd_pkg::cmd_type    cmd;
   ssd_pkg::status_type status;

   ssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssd_datapath #(
      .SOURCE_ENTRIES (SOURCE_ENTRIES),
      .SET_DEPTH      (SET_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_ether_kind  (req_ether_kind),
      .req_ip_proto    (req_ip_proto),
      .req_syn_bit     (req_syn_bit),
      .req_ack_bit     (req_ack_bit),
      .req_src_addr    (req_src_addr),
      .req_dst_addr    (req_dst_addr),
      .req_target_port (req_target_port),
      .rsp_frame_class (rsp_frame_class),
      .rsp_arp_alert   (rsp_arp_alert),
      .rsp_port_alert  (rsp_port_alert),
      .rsp_host_alert  (rsp_host_alert),
      .rsp_table_full  (rsp_table_full),
      .rsp_alert_addr  (rsp_alert_addr),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

/* rtl/ssd_ctrl.sv */
`timescale 1ns / 1ps

module ssd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ssd_pkg::status_type status,
   output ssd_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SRC_RD    = 4'd1;
   localparam logic [3:0] S_SRC_CMP   = 4'd2;
   localparam logic [3:0] S_FILL_RD   = 4'd3;
   localparam logic [3:0] S_FILL_CAP  = 4'd4;
   localparam logic [3:0] S_HOST_RD   = 4'd5;
   localparam logic [3:0] S_HOST_CMP  = 4'd6;
   localparam logic [3:0] S_HOST_ADD  = 4'd7;
   localparam logic [3:0] S_PORT_RD   = 4'd8;
   localparam logic [3:0] S_PORT_CMP  = 4'd9;
   localparam logic [3:0] S_PORT_ADD  = 4'd10;
   localparam logic [3:0] S_WB        = 4'd11;
   localparam logic [3:0] S_FIN       = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.idx_clr  = 1'b1;
               if (status.req_class == ssd_pkg::CLASS_SYN) state_in = S_SRC_RD;
               else state_in = S_FIN;
            end
         end
         S_SRC_RD: begin
            if (status.src_end) begin
               if (status.tbl_full) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_FIN;
               end else begin
                  cmd.alloc   = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in    = S_HOST_RD;
               end
            end else begin
               cmd.rd_src = 1'b1;
               state_in   = S_SRC_CMP;
            end
         end
         S_SRC_CMP: begin
            if (status.src_hit) begin
               cmd.set_slot = 1'b1;
               state_in     = S_FILL_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRC_RD;
            end
         end
         S_FILL_RD: begin
            cmd.rd_fill = 1'b1;
            state_in    = S_FILL_CAP;
         end
         S_FILL_CAP: begin
            cmd.cap_fill = 1'b1;
            cmd.idx_clr  = 1'b1;
            state_in     = S_HOST_RD;
         end
         S_HOST_RD: begin
            if (status.host_end) begin
               state_in = S_HOST_ADD;
            end else begin
               cmd.rd_host = 1'b1;
               state_in    = S_HOST_CMP;
            end
         end
         S_HOST_CMP: begin
            if (status.host_hit) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_PORT_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_HOST_RD;
            end
         end
         S_HOST_ADD: begin
            cmd.add_host = 1'b1;
            cmd.idx_clr  = 1'b1;
            state_in     = S_PORT_RD;
         end
         S_PORT_RD: begin
            if (status.port_end) begin
               state_in = S_PORT_ADD;
            end else begin
               cmd.rd_port = 1'b1;
               state_in    = S_PORT_CMP;
            end
         end
         S_PORT_CMP: begin
            if (status.port_hit) begin
               state_in = S_WB;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_PORT_RD;
            end
         end
         S_PORT_ADD: begin
            cmd.add_port = 1'b1;
            state_in     = S_WB;
         end
         S_WB: begin
            cmd.wb_fill = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start work");
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && rsp_stall) |=> (state_ff == S_FIN))
      else $error("result overwrote a pending transaction");
   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !status.tbl_full)
      else $error("allocation with full table");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

/* rtl/ssd_datapath.sv */
`timescale 1ns / 1ps

module ssd_datapath #(
   parameter int SOURCE_ENTRIES = ssd_pkg::SOURCE_ENTRIES_DEF,
   parameter int SET_DEPTH      = ssd_pkg::SET_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic [15:0]         req_ether_kind,
   input  logic [7:0]          req_ip_proto,
   input  logic                req_syn_bit,
   input  logic                req_ack_bit,
   input  logic [31:0]         req_src_addr,
   input  logic [31:0]         req_dst_addr,
   input  logic [15:0]         req_target_port,
   output logic [1:0]          rsp_frame_class,
   output logic                rsp_arp_alert,
   output logic                rsp_port_alert,
   output logic                rsp_host_alert,
   output logic                rsp_table_full,
   output logic [31:0]         rsp_alert_addr,
   input  ssd_pkg::cmd_type    cmd,
   output ssd_pkg::status_type status
);

   localparam int SW   = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
   localparam int CW   = $clog2(SOURCE_ENTRIES + 1);
   localparam int IW   = $clog2(SET_DEPTH);
   localparam int FW   = $clog2(SET_DEPTH + 1);
   localparam int XW   = (CW > FW) ? CW : FW;
   localparam int CMPW = (FW > 4) ? FW : 4;
   localparam int SETN = SOURCE_ENTRIES << IW;

   // configuration
   logic [7:0] arp_limit_ff;
   logic [3:0] port_limit_ff, host_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arp_limit_ff  <= ssd_pkg::ARP_LIMIT_RST;
         port_limit_ff <= ssd_pkg::PORT_LIMIT_RST;
         host_limit_ff <= ssd_pkg::HOST_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ssd_pkg::REG_ARP_LIMIT:  arp_limit_ff  <= csr_wdata;
            ssd_pkg::REG_PORT_LIMIT: port_limit_ff <= csr_wdata[3:0];
            ssd_pkg::REG_HOST_LIMIT: host_limit_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // classification of the offered transaction
   logic [1:0] req_class;
   always_comb begin
      if (req_ether_kind == ssd_pkg::KIND_ARP) req_class = ssd_pkg::CLASS_ARP;
      else if (req_ether_kind == ssd_pkg::KIND_IPV4 && req_ip_proto == ssd_pkg::PROTO_TCP &&
               req_syn_bit && !req_ack_bit) req_class = ssd_pkg::CLASS_SYN;
      else req_class = ssd_pkg::CLASS_OTHER;
   end

   // control-side state
   logic [7:0]    arp_tally_ff;
   logic [CW-1:0] count_ff;
   logic [XW-1:0] idx_ff;
   logic [SW-1:0] slot_ff;
   logic [FW-1:0] hfill_ff, pfill_ff;
   logic [8:0]    arp_next;

   assign arp_next = {1'b0, arp_tally_ff} + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arp_tally_ff <= '0;
         count_ff     <= '0;
      end else begin
         if (cmd.load_req && req_class == ssd_pkg::CLASS_ARP) begin
            if (arp_next > {1'b0, arp_limit_ff}) arp_tally_ff <= '0;
            else arp_tally_ff <= arp_next[7:0];
         end
         if (cmd.alloc) count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + XW'(1);
   end

   // per-transaction payload
   logic [1:0]  cls_ff;
   logic        arp_al_ff, port_al_ff, host_al_ff, full_ff;
   logic [31:0] src_ff, dst_ff;
   logic [15:0] port_ff;

   logic [FW-1:0] hnext, pnext;
   logic          host_over, port_over;

   assign hnext     = hfill_ff + FW'(1);
   assign pnext     = pfill_ff + FW'(1);
   assign host_over = (hfill_ff == FW'(SET_DEPTH)) || (CMPW'(hnext) > CMPW'(host_limit_ff));
   assign port_over = (pfill_ff == FW'(SET_DEPTH)) || (CMPW'(pnext) > CMPW'(port_limit_ff));

   // memories
   logic [31:0]     src_mem [SOURCE_ENTRIES];
   logic [2*FW-1:0] fill_mem [SOURCE_ENTRIES];
   logic [31:0]     host_mem [SETN];
   logic [15:0]     port_mem [SETN];
   logic [31:0]     src_rd_ff, host_rd_ff;
   logic [2*FW-1:0] fill_rd_ff;
   logic [15:0]     port_rd_ff;
   logic [SW+IW-1:0] rd_addr;

   assign rd_addr = {slot_ff, idx_ff[IW-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.alloc) src_mem[count_ff[SW-1:0]] <= src_ff;
      if (cmd.rd_src) src_rd_ff <= src_mem[idx_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.wb_fill) fill_mem[slot_ff] <= {hfill_ff, pfill_ff};
      if (cmd.rd_fill) fill_rd_ff <= fill_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_host && hfill_ff != FW'(SET_DEPTH))
         host_mem[{slot_ff, hfill_ff[IW-1:0]}] <= dst_ff;
      if (cmd.rd_host) host_rd_ff <= host_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_port && pfill_ff != FW'(SET_DEPTH))
         port_mem[{slot_ff, pfill_ff[IW-1:0]}] <= port_ff;
      if (cmd.rd_port) port_rd_ff <= port_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cls_ff     <= req_class;
         arp_al_ff  <= (req_class == ssd_pkg::CLASS_ARP) && (arp_next > {1'b0, arp_limit_ff});
         port_al_ff <= 1'b0;
         host_al_ff <= 1'b0;
         full_ff    <= 1'b0;
         src_ff     <= req_src_addr;
         dst_ff     <= req_dst_addr;
         port_ff    <= req_target_port;
      end
      if (cmd.set_full) full_ff <= 1'b1;
      if (cmd.alloc) begin
         slot_ff  <= count_ff[SW-1:0];
         hfill_ff <= '0;
         pfill_ff <= '0;
      end
      if (cmd.set_slot) slot_ff <= idx_ff[SW-1:0];
      if (cmd.cap_fill) begin
         hfill_ff <= fill_rd_ff[2*FW-1:FW];
         pfill_ff <= fill_rd_ff[FW-1:0];
      end
      if (cmd.add_host) begin
         host_al_ff <= host_over;
         hfill_ff   <= host_over ? '0 : hnext;
      end
      if (cmd.add_port) begin
         port_al_ff <= port_over;
         pfill_ff   <= port_over ? '0 : pnext;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_frame_class <= cls_ff;
         rsp_arp_alert   <= arp_al_ff;
         rsp_port_alert  <= port_al_ff;
         rsp_host_alert  <= host_al_ff;
         rsp_table_full  <= full_ff;
         rsp_alert_addr  <= (port_al_ff || host_al_ff) ? src_ff : 32'd0;
      end
   end

   always_comb begin
      status.req_class = req_class;
      status.src_end   = (idx_ff == XW'(count_ff));
      status.tbl_full  = (count_ff == CW'(SOURCE_ENTRIES));
      status.src_hit   = (src_rd_ff == src_ff);
      status.host_end  = (idx_ff == XW'(hfill_ff));
      status.host_hit  = (host_rd_ff == dst_ff);
      status.port_end  = (idx_ff == XW'(pfill_ff));
      status.port_hit  = (port_rd_ff == port_ff);
   end

endmodule

/* bench/tb_syn_scan_detector_core.sv */
`timescale 1ns / 1ps

class scan_scoreboard;
   // detector state mirror
   logic [7:0]  arp_lim;
   logic [3:0]  port_lim;
   logic [3:0]  host_lim;
   int unsigned arp_tally;
   bit          used [16];
   logic [31:0] source [16];
   int unsigned pfill [16];
   int unsigned hfill [16];
   logic [15:0] pset [16][16];
   logic [31:0] hset [16][16];
   // expected verdicts
   logic [1:0]  exp_class [$];
   logic        exp_arp [$];
   logic        exp_port [$];
   logic        exp_host [$];
   logic        exp_full [$];
   logic [31:0] exp_addr [$];
   int          errors;

   function new();
      arp_lim = ssd_pkg::ARP_LIMIT_RST;
      port_lim = ssd_pkg::PORT_LIMIT_RST;
      host_lim = ssd_pkg::HOST_LIMIT_RST;
      arp_tally = 0;
      errors = 0;
      foreach (used[i]) begin
         used[i] = 0;
         pfill[i] = 0;
         hfill[i] = 0;
      end
   endfunction

   function void set_limit(logic [1:0] idx, logic [7:0] val);
      if (idx == ssd_pkg::REG_ARP_LIMIT) arp_lim = val;
      else if (idx == ssd_pkg::REG_PORT_LIMIT) port_lim = val[3:0];
      else if (idx == ssd_pkg::REG_HOST_LIMIT) host_lim = val[3:0];
   endfunction

   function bit add_port(int s, logic [15:0] v);
      int n;
      n = pfill[s];
      for (int i = 0; i < n; i++) if (pset[s][i] == v) return 0;
      if (n >= 16) begin
         pfill[s] = 0;
         return 1;
      end
      pset[s][n] = v;
      n++;
      if (n > port_lim) begin
         pfill[s] = 0;
         return 1;
      end
      pfill[s] = n;
      return 0;
   endfunction

   function bit add_host(int s, logic [31:0] v);
      int n;
      n = hfill[s];
      for (int i = 0; i < n; i++) if (hset[s][i] == v) return 0;
      if (n >= 16) begin
         hfill[s] = 0;
         return 1;
      end
      hset[s][n] = v;
      n++;
      if (n > host_lim) begin
         hfill[s] = 0;
         return 1;
      end
      hfill[s] = n;
      return 0;
   endfunction

   function void note_frame(logic [15:0] kind, logic [7:0] proto, logic syn, logic ack,
                            logic [31:0] src, logic [31:0] dst, logic [15:0] port);
      logic [1:0] cls;
      logic a_arp, a_port, a_host, full;
      logic [31:0] addr;
      int slot, free_slot;
      cls = ssd_pkg::CLASS_OTHER;
      a_arp = 0; a_port = 0; a_host = 0; full = 0; addr = 0;
      if (kind == ssd_pkg::KIND_ARP) begin
         cls = ssd_pkg::CLASS_ARP;
         if (arp_tally + 1 > arp_lim) begin
            a_arp = 1;
            arp_tally = 0;
         end else arp_tally = (arp_tally + 1) & 8'hff;
      end else if (kind == ssd_pkg::KIND_IPV4 && proto == ssd_pkg::PROTO_TCP
                   && syn && !ack) begin
         cls = ssd_pkg::CLASS_SYN;
         slot = -1;
         free_slot = -1;
         for (int i = 0; i < 16; i++) begin
            if (used[i]) begin
               if (slot < 0 && source[i] == src) slot = i;
            end else if (free_slot < 0) free_slot = i;
         end
         if (slot < 0 && free_slot >= 0) begin
            slot = free_slot;
            used[slot] = 1;
            source[slot] = src;
            pfill[slot] = 0;
            hfill[slot] = 0;
         end
         if (slot < 0) full = 1;
         else begin
            a_host = add_host(slot, dst);
            a_port = add_port(slot, port);
            if (a_host || a_port) addr = src;
         end
      end
      exp_class.push_back(cls);
      exp_arp.push_back(a_arp);
      exp_port.push_back(a_port);
      exp_host.push_back(a_host);
      exp_full.push_back(full);
      exp_addr.push_back(addr);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   task check_verdict(logic [1:0] cls, logic a_arp, logic a_port, logic a_host,
                      logic full, logic [31:0] addr);
      if (exp_class.size() == 0) begin
         report("unexpected transaction", 32'd0, 32'd0);
         return;
      end
      if (cls !== exp_class[0]) report("frame_class", 32'(cls), 32'(exp_class[0]));
      if (a_arp !== exp_arp[0]) report("arp_alert", 32'(a_arp), 32'(exp_arp[0]));
      if (a_port !== exp_port[0]) report("port_alert", 32'(a_port), 32'(exp_port[0]));
      if (a_host !== exp_host[0]) report("host_alert", 32'(a_host), 32'(exp_host[0]));
      if (full !== exp_full[0]) report("table_full", 32'(full), 32'(exp_full[0]));
      if (addr !== exp_addr[0]) report("alert_addr", addr, exp_addr[0]);
      void'(exp_class.pop_front());
      void'(exp_arp.pop_front());
      void'(exp_port.pop_front());
      void'(exp_host.pop_front());
      void'(exp_full.pop_front());
      void'(exp_addr.pop_front());
   endtask
endclass

module tb_syn_scan_detector_core;

   // index past the last register, ignored by the block
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [7:0]  csr_wdata = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [15:0] req_ether_kind = 0;
   logic [7:0]  req_ip_proto = 0;
   logic        req_syn_bit = 0;
   logic        req_ack_bit = 0;
   logic [31:0] req_src_addr = 0;
   logic [31:0] req_dst_addr = 0;
   logic [15:0] req_target_port = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_frame_class;
   logic        rsp_arp_alert;
   logic        rsp_port_alert;
   logic        rsp_host_alert;
   logic        rsp_table_full;
   logic [31:0] rsp_alert_addr;

   scan_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   // small pools so sets fill and repeats occur
   logic [31:0] src_pool [24];
   logic [31:0] dst_pool [20];
   logic [15:0] port_pool [20];

   syn_scan_detector_core u_top (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_verdict(rsp_frame_class, rsp_arp_alert, rsp_port_alert, rsp_host_alert,
                          rsp_table_full, rsp_alert_addr);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task send_frame(logic [15:0] kind, logic [7:0] proto, logic syn, logic ack,
                   logic [31:0] src, logic [31:0] dst, logic [15:0] port);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_ether_kind <= kind;
      req_ip_proto <= proto;
      req_syn_bit <= syn;
      req_ack_bit <= ack;
      req_src_addr <= src;
      req_dst_addr <= dst;
      req_target_port <= port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_frame(kind, proto, syn, ack, src, dst, port);
   endtask

   task drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.exp_class.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task write_limit(logic [1:0] idx, logic [7:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.set_limit(idx, val);
      @(posedge clock);
   endtask

   task random_frame();
      int r;
      logic [15:0] kind;
      logic [7:0] proto;
      logic syn, ack;
      r = $urandom_range(99);
      kind = ssd_pkg::KIND_IPV4; proto = ssd_pkg::PROTO_TCP; syn = 1; ack = 0;
      if (r < 20) kind = ssd_pkg::KIND_ARP;
      else if (r < 30) begin
         kind = 16'($urandom);
         proto = 8'($urandom);
         syn = 1'($urandom);
         ack = 1'($urandom);
      end else if (r < 36) ack = 1;
      else if (r < 40) proto = 8'($urandom);
      send_frame(kind, proto, syn, ack,
                 ($urandom_range(9) == 0) ? $urandom : src_pool[$urandom_range(23)],
                 ($urandom_range(9) == 0) ? $urandom : dst_pool[$urandom_range(19)],
                 ($urandom_range(9) == 0) ? 16'($urandom) : port_pool[$urandom_range(19)]);
   endtask

   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      sb = new();
      foreach (src_pool[i]) src_pool[i] = $urandom;
      foreach (dst_pool[i]) dst_pool[i] = $urandom;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, classes, repeats, set overflow
      send_frame(ssd_pkg::KIND_ARP, 8'h00, 0, 0, 32'h0, 32'h0, 16'h0);
      send_frame(16'hffff, 8'hff, 1, 1, 32'hffffffff, 32'hffffffff, 16'hffff);
      send_frame(16'h0000, ssd_pkg::PROTO_TCP, 1, 0, 32'h1, 32'h2, 16'h3);
      send_frame(ssd_pkg::KIND_IPV4, 8'd17, 1, 0, 32'h1, 32'h2, 16'h3);
      send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 1, 1, 32'h1, 32'h2, 16'h3);
      send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 0, 0, 32'h1, 32'h2, 16'h3);
      send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 1, 0,
                 32'hffffffff, 32'hffffffff, 16'hffff);
      send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 1, 0,
                 32'hffffffff, 32'hffffffff, 16'hffff);
      for (int i = 0; i < 12; i++)
         send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 1, 0, 32'h0a000001,
                    32'h100 + i, 16'(80 + i));
      drain();
      // limit 0 on the ARP and port registers and max on the host one; then table full
      write_limit(ssd_pkg::REG_ARP_LIMIT, 8'd0);
      write_limit(ssd_pkg::REG_PORT_LIMIT, 8'd0);
      write_limit(ssd_pkg::REG_HOST_LIMIT, 8'd15);
      send_frame(ssd_pkg::KIND_ARP, 8'h00, 0, 0, 32'h0, 32'h0, 16'h0);
      send_frame(ssd_pkg::KIND_ARP, 8'h00, 0, 0, 32'h0, 32'h0, 16'h0);
      for (int i = 0; i < 18; i++)
         send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 1, 0, 32'h0b000000 + i,
                    32'h5, 16'h5);
      for (int i = 0; i < 17; i++)
         send_frame(ssd_pkg::KIND_IPV4, ssd_pkg::PROTO_TCP, 1, 0, 32'h0b000001,
                    32'h900 + i, 16'h7);
      drain();

      // random phases with different limits and idling; table is now full,
      // so reset-free runs mostly see known sources plus table-full verdicts
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_limit(ssd_pkg::REG_ARP_LIMIT, 8'd255);
               write_limit(ssd_pkg::REG_PORT_LIMIT, 8'd15);
               write_limit(ssd_pkg::REG_HOST_LIMIT, 8'd1);
            end
            1: begin
               write_limit(ssd_pkg::REG_ARP_LIMIT, 8'd3);
               write_limit(ssd_pkg::REG_PORT_LIMIT, 8'd4);
               write_limit(ssd_pkg::REG_HOST_LIMIT, 8'd4);
            end
            2: begin
               write_limit(ssd_pkg::REG_ARP_LIMIT, 8'd1);
               write_limit(ssd_pkg::REG_PORT_LIMIT, 8'd1);
               write_limit(ssd_pkg::REG_HOST_LIMIT, 8'd15);
            end
            3: begin
               write_limit(ssd_pkg::REG_ARP_LIMIT, 8'd20);
               write_limit(ssd_pkg::REG_PORT_LIMIT, 8'd10);
               write_limit(ssd_pkg::REG_HOST_LIMIT, 8'd10);
            end
            4: write_limit(REG_SPARE, 8'($urandom));
            default: begin
               write_limit(ssd_pkg::REG_ARP_LIMIT, 8'd7);
               write_limit(ssd_pkg::REG_PORT_LIMIT, 8'd2);
               write_limit(ssd_pkg::REG_HOST_LIMIT, 8'd3);
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 59; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 59; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         // pools pointing at tracked sources keep sets growing
         for (int i = 0; i < 16; i++) src_pool[i] = sb.source[i];
         for (int k = 0; k < 70; k++) random_frame();
         drain();
      end
      stall_pct = 0;
      drain();

      if (sb.errors == 0 && sb.exp_class.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
